@@ hdl/dwpid_pkg.sv @@
// Shared types, constants and helper functions for the dual-wheel PID
// speed controller. No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dwpid_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_SPEED_LEVEL = 3'd0;
    localparam logic [2:0] CFG_DIRECTION   = 3'd1;
    localparam logic [2:0] CFG_KP_GAIN     = 3'd2;
    localparam logic [2:0] CFG_KI_GAIN     = 3'd3;
    localparam logic [2:0] CFG_KD_GAIN     = 3'd4;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Gain reset values, unsigned Q8.8
    localparam logic [15:0] KP_RESET = 16'd205;
    localparam logic [15:0] KI_RESET = 16'd26;
    localparam logic [15:0] KD_RESET = 16'd13;

    // Update timing and scale factors
    localparam logic [31:0] MIN_DT_MS   = 32'd50;
    localparam logic [32:0] SPEED_SCALE = 33'd256000;  // 1000 ms/s in Q.8
    localparam logic [31:0] MS_PER_S    = 32'd1000;
    localparam int          DIV_STEPS   = 64;

    // Divide by 1000 one base-2^16 digit at a time: ceil(2^36 / 1000)
    localparam logic [26:0] MS_RECIP    = 27'd68719477;
    localparam int          MS_DIGITS   = 4;

    // Direction codes
    localparam logic [2:0] DIR_FWD       = 3'd0;
    localparam logic [2:0] DIR_REV       = 3'd1;
    localparam logic [2:0] DIR_PIVOT_R   = 3'd2;
    localparam logic [2:0] DIR_PIVOT_L   = 3'd3;
    localparam logic [2:0] DIR_ROTATE_CW = 3'd4;
    localparam logic [2:0] DIR_ROTATE_CC = 3'd5;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_COMMIT_TIME,
        OP_MUL_SPEED,
        OP_MUL_INTEG,
        OP_MUL_DERIV,
        OP_MUL_KP,
        OP_MUL_KI,
        OP_MUL_KD,
        OP_DIV_DT,
        OP_DIV_MS,
        OP_SET_ERR,
        OP_SET_INTEG,
        OP_SET_DERIV,
        OP_ACC_LOAD,
        OP_ACC_ADD,
        OP_SET_PWM,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   wheel;
    } dp_cmd_t;

    typedef struct packed {
        logic dt_short;
        logic div_done;
    } dp_stat_t;

    // Target speed in Q.8 ticks per second
    function automatic logic [15:0] target_q8(input logic [1:0] lvl);
        logic [15:0] t;
        case (lvl)
            2'd0:    t = 16'd0;
            2'd1:    t = 16'd50 << 8;
            2'd2:    t = 16'd120 << 8;
            default: t = 16'd255 << 8;
        endcase
        return t;
    endfunction

    // Bridge levels {a_in1, a_in2, b_in1, b_in2}
    function automatic logic [3:0] pin_levels(input logic [2:0] dir);
        logic [3:0] p;
        case (dir)
            DIR_FWD:       p = 4'b1010;
            DIR_REV:       p = 4'b0101;
            DIR_PIVOT_R:   p = 4'b1000;
            DIR_PIVOT_L:   p = 4'b0010;
            DIR_ROTATE_CW: p = 4'b1001;
            DIR_ROTATE_CC: p = 4'b0110;
            default:       p = 4'b0000;
        endcase
        return p;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
        logic signed [39:0] r;
        if (v > 64'sh0000_007F_FFFF_FFFF) begin
            r = 40'sh7F_FFFF_FFFF;
        end else if (v < -64'sh0000_0080_0000_0000) begin
            r = 40'sh80_0000_0000;
        end else begin
            r = v[39:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/dwpid_div.sv @@
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Depends on dwpid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dwpid_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [63:0] num,
    input  wire logic        [31:0] den,
    output logic                    done,
    output logic signed [63:0]      quot
);
    import dwpid_pkg::*;

    logic        [31:0] den_reg;
    logic        [31:0] rem_reg;
    logic        [63:0] quo_reg;
    logic               neg_reg;
    logic        [6:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic        [32:0] trial;
    logic               fits;
    logic        [63:0] num_mag;

    assign num_mag = num[63] ? (~num + 64'd1) : num;
    assign trial   = {rem_reg, quo_reg[63]};
    assign fits    = trial >= {1'b0, den_reg};

    // Shift in one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(DIV_STEPS);
                rem_reg  <= '0;
                quo_reg  <= num_mag;
                neg_reg  <= num[63];
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg <= fits ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
                quo_reg <= {quo_reg[62:0], fits};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? $signed(~quo_reg + 64'd1) : $signed(quo_reg);

endmodule

`default_nettype wire

@@ hdl/dwpid_dpath.sv @@
// Datapath: configuration, per-wheel PID state, shared multiplier and
// divider, divide-by-1000 unit, output word registers. Depends on dwpid_pkg and dwpid_div.
`timescale 1ns / 1ps
`default_nettype none

module dwpid_dpath (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire dwpid_pkg::dp_cmd_t                   cmd,
    output dwpid_pkg::dp_stat_t                       stat,
    input  wire logic                                 cfg_we,
    input  wire logic [dwpid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dwpid_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [31:0]                          s_now_ms,
    input  wire logic signed [31:0]                   s_count_a,
    input  wire logic signed [31:0]                   s_count_b,
    output logic [7:0]                                m_pwm_a,
    output logic [7:0]                                m_pwm_b,
    output logic                                      m_a_in1,
    output logic                                      m_a_in2,
    output logic                                      m_b_in1,
    output logic                                      m_b_in2
);
    import dwpid_pkg::*;

    // Configuration
    logic [1:0]  speed_level_reg;
    logic [2:0]  direction_reg;
    logic [15:0] kp_reg, ki_reg, kd_reg;

    // Update state
    logic [31:0]        last_reg;
    logic [31:0]        now_reg;
    logic [31:0]        dt_reg;
    logic [31:0]        cnt_reg      [2];
    logic [31:0]        prev_cnt_reg [2];
    logic signed [39:0] integ_reg    [2];
    logic signed [31:0] perr_reg     [2];
    logic signed [31:0] err_reg;
    logic signed [39:0] deriv_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic [7:0]         pwm_reg      [2];
    logic [7:0]         out_pwm_reg  [2];
    logic [3:0]         out_pins_reg;

    logic               w;
    logic signed [40:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [73:0] mul_p;
    logic               div_start;
    logic signed [63:0] div_num;
    logic [31:0]        div_den;
    logic               div_done;
    logic signed [63:0] div_quot;
    logic signed [63:0] err_diff;
    logic signed [63:0] integ_sum;
    logic [31:0]        delta;
    logic [7:0]         pwm_val;

    // Divide-by-1000 unit
    logic               ms_start;
    logic [63:0]        ms_mag_reg;
    logic [63:0]        ms_quo_reg;
    logic [9:0]         ms_rem_reg;
    logic [2:0]         ms_cnt_reg;
    logic               ms_busy_reg;
    logic               ms_done_reg;
    logic               ms_neg_reg;
    logic [25:0]        ms_cur;
    logic [52:0]        ms_prod;
    logic [15:0]        ms_digit;
    logic [25:0]        ms_back;
    logic signed [63:0] ms_quot;

    assign w = cmd.wheel;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_level_reg <= '0;
            direction_reg   <= '0;
            kp_reg          <= KP_RESET;
            ki_reg          <= KI_RESET;
            kd_reg          <= KD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SPEED_LEVEL: speed_level_reg <= cfg_data[1:0];
                CFG_DIRECTION:   direction_reg   <= cfg_data[2:0];
                CFG_KP_GAIN:     kp_reg          <= cfg_data;
                CFG_KI_GAIN:     ki_reg          <= cfg_data;
                CFG_KD_GAIN:     kd_reg          <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Select multiplier operands
    assign delta = cnt_reg[w] - prev_cnt_reg[w];
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_SPEED: begin
                mul_a = 41'($signed(delta));
                mul_b = $signed(SPEED_SCALE);
            end
            OP_MUL_INTEG: begin
                mul_a = 41'(err_reg);
                mul_b = $signed({1'b0, dt_reg});
            end
            OP_MUL_DERIV: begin
                mul_a = 41'(err_reg) - 41'(perr_reg[w]);
                mul_b = $signed({1'b0, MS_PER_S});
            end
            OP_MUL_KP: begin
                mul_a = 41'(err_reg);
                mul_b = $signed({17'd0, kp_reg});
            end
            OP_MUL_KI: begin
                mul_a = 41'(integ_reg[w]);
                mul_b = $signed({17'd0, ki_reg});
            end
            OP_MUL_KD: begin
                mul_a = 41'(deriv_reg);
                mul_b = $signed({17'd0, kd_reg});
            end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Shared divider for the divisions by dt
    assign div_start = (cmd.op == OP_DIV_DT);
    assign div_num   = prod_reg;
    assign div_den   = dt_reg;

    dwpid_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Divide the magnitude by 1000 one 16-bit digit per cycle, top digit first
    assign ms_start = (cmd.op == OP_DIV_MS);
    assign ms_cur   = {ms_rem_reg, ms_mag_reg[63:48]};
    assign ms_prod  = 53'(ms_cur) * 53'(MS_RECIP);
    assign ms_digit = ms_prod[51:36];
    assign ms_back  = 26'(ms_digit) * 26'(MS_PER_S);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_busy_reg <= 1'b0;
            ms_done_reg <= 1'b0;
            ms_cnt_reg  <= '0;
        end else begin
            ms_done_reg <= 1'b0;
            if (ms_start) begin
                ms_busy_reg <= 1'b1;
                ms_cnt_reg  <= 3'(MS_DIGITS);
                ms_rem_reg  <= '0;
                ms_mag_reg  <= prod_reg[63] ? (~prod_reg + 64'sd1) : prod_reg;
                ms_neg_reg  <= prod_reg[63];
            end else if (ms_busy_reg) begin
                ms_rem_reg <= 10'(ms_cur - ms_back);
                ms_mag_reg <= {ms_mag_reg[47:0], 16'd0};
                ms_quo_reg <= {ms_quo_reg[47:0], ms_digit};
                ms_cnt_reg <= ms_cnt_reg - 3'd1;
                if (ms_cnt_reg == 3'd1) begin
                    ms_busy_reg <= 1'b0;
                    ms_done_reg <= 1'b1;
                end
            end
        end
    end

    assign ms_quot = ms_neg_reg ? $signed(~ms_quo_reg + 64'd1) : $signed(ms_quo_reg);

    assign err_diff  = $signed({48'd0, target_q8(speed_level_reg)}) - div_quot;
    assign integ_sum = 64'(integ_reg[w]) + ms_quot;

    // Clamp accumulated Q.16 sum to 0..255
    always_comb begin
        if (acc_reg[63] || acc_reg == 64'sd0) begin
            pwm_val = 8'd0;
        end else if (|acc_reg[62:24]) begin
            pwm_val = 8'd255;
        end else begin
            pwm_val = acc_reg[23:16];
        end
    end

    // Execute the issued operation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg     <= '0;
            prev_cnt_reg <= '{default: '0};
            integ_reg    <= '{default: '0};
            perr_reg     <= '{default: '0};
        end else begin
            case (cmd.op)
                OP_LOAD: begin
                    now_reg    <= s_now_ms;
                    cnt_reg[0] <= s_count_a;
                    cnt_reg[1] <= s_count_b;
                    dt_reg     <= s_now_ms - last_reg;
                end
                OP_COMMIT_TIME: last_reg <= now_reg;
                OP_MUL_SPEED, OP_MUL_INTEG, OP_MUL_DERIV,
                OP_MUL_KP, OP_MUL_KI, OP_MUL_KD: prod_reg <= mul_p[63:0];
                OP_SET_ERR: begin
                    err_reg         <= sat32(err_diff);
                    prev_cnt_reg[w] <= cnt_reg[w];
                end
                OP_SET_INTEG: integ_reg[w] <= sat40(integ_sum);
                OP_SET_DERIV: begin
                    deriv_reg   <= div_quot[39:0];
                    perr_reg[w] <= err_reg;
                end
                OP_ACC_LOAD: acc_reg <= prod_reg;
                OP_ACC_ADD:  acc_reg <= acc_reg + prod_reg;
                OP_SET_PWM:  pwm_reg[w] <= pwm_val;
                OP_OUT: begin
                    out_pwm_reg  <= pwm_reg;
                    out_pins_reg <= pin_levels(direction_reg);
                end
                default: ;
            endcase
        end
    end

    assign stat.dt_short = dt_reg < MIN_DT_MS;
    assign stat.div_done = div_done || ms_done_reg;

    assign m_pwm_a = out_pwm_reg[0];
    assign m_pwm_b = out_pwm_reg[1];
    assign m_a_in1 = out_pins_reg[3];
    assign m_a_in2 = out_pins_reg[2];
    assign m_b_in1 = out_pins_reg[1];
    assign m_b_in2 = out_pins_reg[0];

endmodule

`default_nettype wire

@@ hdl/dwpid_ctrl.sv @@
// Controller: sequences the datapath through one update for each wheel
// and runs both handshakes. Depends on dwpid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dwpid_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output dwpid_pkg::dp_cmd_t         cmd,
    input  wire dwpid_pkg::dp_stat_t   stat
);
    import dwpid_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_MUL, ST_POST, ST_DIV, ST_STORE, ST_OUT
    } state_t;

    // Steps of one wheel update
    localparam logic [2:0] STEP_SPEED = 3'd0;
    localparam logic [2:0] STEP_INTEG = 3'd1;
    localparam logic [2:0] STEP_DERIV = 3'd2;
    localparam logic [2:0] STEP_KP    = 3'd3;
    localparam logic [2:0] STEP_KI    = 3'd4;
    localparam logic [2:0] STEP_KD    = 3'd5;
    localparam logic [2:0] STEP_PWM   = 3'd6;

    state_t     state_reg;
    logic [2:0] step_reg;
    logic       wheel_reg;
    logic       m_valid_reg;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Decode the operation for this cycle
    always_comb begin
        cmd.wheel = wheel_reg;
        cmd.op    = OP_NONE;
        case (state_reg)
            ST_IDLE:  if (s_valid) cmd.op = OP_LOAD;
            ST_CHECK: if (!stat.dt_short) cmd.op = OP_COMMIT_TIME;
            ST_MUL: begin
                case (step_reg)
                    STEP_SPEED: cmd.op = OP_MUL_SPEED;
                    STEP_INTEG: cmd.op = OP_MUL_INTEG;
                    STEP_DERIV: cmd.op = OP_MUL_DERIV;
                    STEP_KP:    cmd.op = OP_MUL_KP;
                    STEP_KI:    cmd.op = OP_MUL_KI;
                    STEP_KD:    cmd.op = OP_MUL_KD;
                    default:    cmd.op = OP_SET_PWM;
                endcase
            end
            ST_POST: begin
                case (step_reg)
                    STEP_INTEG: cmd.op = OP_DIV_MS;
                    STEP_SPEED,
                    STEP_DERIV: cmd.op = OP_DIV_DT;
                    STEP_KP:    cmd.op = OP_ACC_LOAD;
                    default:    cmd.op = OP_ACC_ADD;
                endcase
            end
            ST_STORE: begin
                case (step_reg)
                    STEP_SPEED: cmd.op = OP_SET_ERR;
                    STEP_INTEG: cmd.op = OP_SET_INTEG;
                    default:    cmd.op = OP_SET_DERIV;
                endcase
            end
            ST_OUT:   if (out_free) cmd.op = OP_OUT;
            default:  ;
        endcase
    end

    // Advance the sequence and hold the output word flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_SPEED;
            wheel_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    step_reg  <= STEP_SPEED;
                    wheel_reg <= 1'b0;
                    state_reg <= stat.dt_short ? ST_IDLE : ST_MUL;
                end
                ST_MUL: begin
                    if (step_reg == STEP_PWM) begin
                        step_reg <= STEP_SPEED;
                        if (wheel_reg) begin
                            state_reg <= ST_OUT;
                        end else begin
                            wheel_reg <= 1'b1;
                        end
                    end else begin
                        state_reg <= ST_POST;
                    end
                end
                ST_POST: begin
                    if (step_reg == STEP_SPEED || step_reg == STEP_INTEG ||
                        step_reg == STEP_DERIV) begin
                        state_reg <= ST_DIV;
                    end else begin
                        step_reg  <= step_reg + 3'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_DIV: begin
                    if (stat.div_done) state_reg <= ST_STORE;
                end
                ST_STORE: begin
                    step_reg  <= step_reg + 3'd1;
                    state_reg <= ST_MUL;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

@@ hdl/dual_wheel_pid_speed_control_unit.sv @@
// Top level of the dual-wheel PID speed controller: controller plus
// datapath. Depends on dwpid_pkg, dwpid_ctrl and dwpid_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted input word carries a millisecond timestamp and two encoder
// counts. If fewer than 50 ms have passed since the last update the word is
// dropped with no result and no change to the stored time or wheel state.
// Otherwise the block runs one PID update per wheel and presents one output
// word with both duty values and the bridge levels for the current direction.
// Per wheel, the speed and derivative divisions each run on one shared
// 64-step bit-serial divider, the integral increment is divided by 1000 in a
// four-step reciprocal unit, and the three gain products are summed and the
// duty clamped, with six passes through the shared multiplier per wheel; a
// check state comes before the updates and an output state after them.
// One word is in work at a time; a new input word is taken while a finished
// output word still waits. Configuration writes land at once and are meant
// for idle periods only.
module dual_wheel_pid_speed_control_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [dwpid_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dwpid_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [31:0]                       s_now_ms,
    input  wire logic signed [31:0]                s_count_a,
    input  wire logic signed [31:0]                s_count_b,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [7:0]                             m_pwm_a,
    output logic [7:0]                             m_pwm_b,
    output logic                                   m_a_in1,
    output logic                                   m_a_in2,
    output logic                                   m_b_in1,
    output logic                                   m_b_in2
);
    import dwpid_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dwpid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    dwpid_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_now_ms  (s_now_ms),
        .s_count_a (s_count_a),
        .s_count_b (s_count_b),
        .m_pwm_a   (m_pwm_a),
        .m_pwm_b   (m_pwm_b),
        .m_a_in1   (m_a_in1),
        .m_a_in2   (m_a_in2),
        .m_b_in1   (m_b_in1),
        .m_b_in2   (m_b_in2)
    );

    // An accepted word keeps the block busy through at least the check state
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while previous word still in check");

    // The divider only finishes during an update
    a_div_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> !s_ready)
        else $error("divider finished while controller idle");

    // A new output word is only raised while the port is free
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_OUT |-> !m_valid || m_ready)
        else $error("output word overwritten before it was taken");

    // Reset leaves no output word pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
